FILE: src/cps_pkg.sv
`timescale 1ns / 1ps

package cps_pkg;

  // Field widths fixed by the stream format
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int POS_W       = 12;
  localparam int NUC_W       = 2;
  localparam int PAT_W       = 16;
  localparam int GI_W        = 13;
  localparam int PLEN_W      = 4;
  localparam int MC_W        = 4;

  // Input tdata layout, lowest field first
  localparam int WPOS_LSB    = 0;
  localparam int NUC_LSB     = WPOS_LSB + POS_W;
  localparam int START_LSB   = NUC_LSB + NUC_W;
  localparam int PAT_LSB     = START_LSB + POS_W;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;

  // Symbols skipped after the start: fixed branch body plus child references
  localparam int BRANCH_BODY = 14;

  localparam logic [CFG_DATA_W-1:0] GENOME_LENGTH_RST   = 13'd4096;
  localparam logic [PLEN_W-1:0]     PROMOTER_LENGTH_RST = 4'd2;
  localparam logic [MC_W-1:0]       MAX_CHILDREN_RST    = 4'd4;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_GENOME_LENGTH   = 2'd0,
    CFG_PROMOTER_LENGTH = 2'd1,
    CFG_MAX_CHILDREN    = 2'd2
  } cfg_index_t;

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_MOD_START = 5'b00010,
    ST_MOD_FIRST = 5'b00100,
    ST_SCAN      = 5'b01000,
    ST_REPORT    = 5'b10000
  } state_t;

  typedef struct packed {
    logic write;
    logic load_search;
    logic kick_first;
    logic begin_scan;
    logic step_sym;
    logic next_pos;
    logic set_found;
    logic set_notfound;
    logic emit;
  } cps_cmd_t;

  typedef struct packed {
    logic mod_done;
    logic range_empty;
    logic plen_zero;
    logic sym_ok;
    logic last_sym;
    logic next_is_last;
    logic out_free;
  } cps_stat_t;

endpackage

FILE: src/cps_mod.sv
`timescale 1ns / 1ps

module cps_mod #(
  parameter int DW = 14,
  parameter int LW = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [LW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] rem
);

  localparam int DSW = DW + LW - 1;
  localparam int KW  = (DW > 1) ? $clog2(DW) : 1;

  logic           busy;
  logic [KW-1:0]  k;
  logic [DSW-1:0] dsh;
  logic           ge;

  assign ge = DSW'(rem) >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        k    <= KW'(DW - 1);
      end else if (busy) begin
        if (k == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          k <= k - 1'b1;
        end
      end
    end
  end

  // Restoring reduction: one shifted divisor per cycle, highest first
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      dsh <= DSW'(divisor) << (DW - 1);
    end else if (busy) begin
      if (ge) rem <= rem - dsh[DW-1:0];
      dsh <= dsh >> 1;
    end
  end

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("reduction restarted while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $fell(busy))
    else $error("done without finishing the last step");
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    done |-> (DSW'(rem) < DSW'(divisor)))
    else $error("remainder not below divisor");
`endif

endmodule

FILE: src/cps_ctrl.sv
`timescale 1ns / 1ps

module cps_ctrl
  import cps_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  input  logic      s_tuser,
  output logic      s_tready,
  input  cps_stat_t st,
  output cps_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == CMD_SEARCH) begin
            cmd.load_search = 1'b1;
            state_next      = ST_MOD_START;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      ST_MOD_START: begin
        if (st.mod_done) begin
          cmd.kick_first = 1'b1;
          state_next     = ST_MOD_FIRST;
        end
      end
      ST_MOD_FIRST: begin
        if (st.mod_done) begin
          if (st.range_empty) begin
            cmd.set_notfound = 1'b1;
            state_next       = ST_REPORT;
          end else begin
            cmd.begin_scan = 1'b1;
            state_next     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (st.plen_zero || (st.sym_ok && st.last_sym)) begin
          cmd.set_found = 1'b1;
          state_next    = ST_REPORT;
        end else if (st.sym_ok) begin
          cmd.step_sym = 1'b1;
        end else if (st.next_is_last) begin
          cmd.set_notfound = 1'b1;
          state_next       = ST_REPORT;
        end else begin
          cmd.next_pos = 1'b1;
        end
      end
      ST_REPORT: begin
        // hold until the output register can take the result
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: src/cps_datapath.sv
`timescale 1ns / 1ps

module cps_datapath
  import cps_pkg::*;
#(
  parameter int GENOME_MAX   = 4096,
  parameter int PROMOTER_MAX = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  cps_cmd_t               cmd,
  output cps_stat_t              st,
  input  logic                   m_tready,
  output logic                   m_tvalid,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tuser
);

  localparam int AW = $clog2(GENOME_MAX);
  localparam int LW = AW + 1;
  localparam int DW = ((POS_W > LW) ? POS_W : LW) + 1;

  logic [CFG_DATA_W-1:0] genome_length;
  logic [PLEN_W-1:0]     promoter_length;
  logic [MC_W-1:0]       max_children;

  logic [POS_W-1:0] wpos;
  logic [NUC_W-1:0] nuc;
  logic [POS_W-1:0] sstart;
  logic [PAT_W-1:0] pat_in;
  logic             wpos_ok;

  logic [LW-1:0]     len_c, len;
  logic [PLEN_W-1:0] plen_c, plen;
  logic [PAT_W-1:0]  patt, patw;
  logic [AW-1:0]     i, a, a_next, last;
  logic [PLEN_W-1:0] j;
  logic [NUC_W-1:0]  rdata;
  logic [LW-1:0]     a_inc_w, i_inc_w;
  logic [AW-1:0]     a_inc, i_inc;
  logic              found_r;
  logic [GI_W-1:0]   gi_r, out_gi;

  logic          mod_start, mod_done;
  logic [DW-1:0] mod_dividend, mod_rem;
  logic [AW:0]   gi_sum;

  logic [NUC_W-1:0] genome [GENOME_MAX];

  assign wpos    = s_tdata[WPOS_LSB +: POS_W];
  assign nuc     = s_tdata[NUC_LSB +: NUC_W];
  assign sstart  = s_tdata[START_LSB +: POS_W];
  assign pat_in  = s_tdata[PAT_LSB +: PAT_W];
  assign wpos_ok = 32'(wpos) < GENOME_MAX;

  always_ff @(posedge clk) begin
    if (rst) begin
      genome_length   <= GENOME_LENGTH_RST;
      promoter_length <= PROMOTER_LENGTH_RST;
      max_children    <= MAX_CHILDREN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GENOME_LENGTH:   genome_length   <= cfg_data;
        CFG_PROMOTER_LENGTH: promoter_length <= cfg_data[PLEN_W-1:0];
        CFG_MAX_CHILDREN:    max_children    <= cfg_data[MC_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the length into 1..GENOME_MAX and the pattern length to PROMOTER_MAX
  always_comb begin
    if (genome_length == '0)                 len_c = LW'(1);
    else if (32'(genome_length) > GENOME_MAX) len_c = LW'(GENOME_MAX);
    else                                     len_c = LW'(genome_length);
    if (32'(promoter_length) > PROMOTER_MAX) plen_c = PLEN_W'(PROMOTER_MAX);
    else                                     plen_c = promoter_length;
  end

  // First pass reduces the start, second pass the skipped-ahead position
  assign mod_start    = cmd.load_search || cmd.kick_first;
  assign mod_dividend = cmd.load_search ? DW'(sstart)
                      : mod_rem + DW'(BRANCH_BODY) + DW'(plen * max_children);

  cps_mod #(.DW(DW), .LW(LW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (len_c),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign a_inc_w = LW'(a) + 1'b1;
  assign a_inc   = (a_inc_w == len) ? '0 : a_inc_w[AW-1:0];
  assign i_inc_w = LW'(i) + 1'b1;
  assign i_inc   = (i_inc_w == len) ? '0 : i_inc_w[AW-1:0];

  always_comb begin
    a_next = a;
    if (cmd.begin_scan)    a_next = AW'(mod_rem);
    else if (cmd.step_sym) a_next = a_inc;
    else if (cmd.next_pos) a_next = i_inc;
  end

  // Read one symbol each cycle at the next scan address
  always_ff @(posedge clk) begin
    if (cmd.write && wpos_ok) genome[AW'(wpos)] <= nuc;
    rdata <= genome[a_next];
  end

  assign gi_sum = (AW + 1)'(i) + (AW + 1)'(plen);

  always_ff @(posedge clk) begin
    a <= a_next;
    if (cmd.load_search) begin
      len  <= len_c;
      plen <= plen_c;
      patt <= pat_in;
    end
    if (cmd.kick_first) begin
      last <= (mod_rem == '0) ? AW'(len - 1'b1) : AW'(mod_rem - 1'b1);
    end
    if (cmd.begin_scan) begin
      i    <= AW'(mod_rem);
      j    <= '0;
      patw <= patt;
    end
    if (cmd.step_sym) begin
      j    <= j + 1'b1;
      patw <= patw >> NUC_W;
    end
    if (cmd.next_pos) begin
      i    <= i_inc;
      j    <= '0;
      patw <= patt;
    end
    if (cmd.set_found) begin
      found_r <= 1'b1;
      gi_r    <= GI_W'(gi_sum);
    end
    if (cmd.set_notfound) begin
      found_r <= 1'b0;
      gi_r    <= '0;
    end
    if (cmd.emit) begin
      m_tuser <= found_r;
      out_gi  <= gi_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)           m_tvalid <= 1'b0;
    else if (cmd.emit) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  assign m_tdata = {(OUT_TDATA_W - GI_W)'(0), out_gi};

  assign st.mod_done     = mod_done;
  assign st.range_empty  = AW'(mod_rem) == last;
  assign st.plen_zero    = plen == '0;
  assign st.sym_ok       = rdata == patw[NUC_W-1:0];
  assign st.last_sym     = ({1'b0, j} + 1'b1) == {1'b0, plen};
  assign st.next_is_last = i_inc == last;
  assign st.out_free     = !m_tvalid || m_tready;

`ifndef ASSERT_OFF
  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.step_sym || cmd.next_pos) |-> (LW'(a) < len && LW'(i) < len))
    else $error("scan address outside the genome");
  a_sym_count: assert property (@(posedge clk) disable iff (rst)
    cmd.step_sym |-> (({1'b0, j} + 1'b1) < {1'b0, plen}))
    else $error("symbol step beyond the pattern length");
  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.begin_scan |-> (AW'(mod_rem) != last))
    else $error("scan started on an empty range");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result overwrote an untaken result");
`endif

endmodule

FILE: src/circular_promoter_search.sv
`timescale 1ns / 1ps

// Circular promoter search over a store of 2-bit nucleotides. An input request
// with tuser 0 writes one nucleotide and gives no result; with tuser 1 it
// searches for the packed pattern, starting promoter_length * max_children +
// 14 symbols past the start position and wrapping around the genome, and gives
// one result: tuser is the found flag, tdata the match position plus
// promoter_length (zero when not found). A search first reduces its start and
// skip positions modulo the genome length in two shift-subtract passes, then
// compares one stored symbol per cycle through the single read port of the
// store. A search waits with its result while the output register is still
// full. One request is worked on at a time; a finished result waits in the
// output register while the next request is taken. Configuration writes are
// taken at any time but belong to idle periods.

module circular_promoter_search
  import cps_pkg::*;
#(
  parameter int GENOME_MAX   = 4096,
  parameter int PROMOTER_MAX = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // write_position[11:0], nucleotide[13:12], search_start[25:14], pattern[41:26]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // command[0]
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // gene_index[12:0]
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // found[0]
  output logic                   m_tuser
);

  cps_cmd_t  cmd;
  cps_stat_t st;

  assign cfg_ready = 1'b1;

  cps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  cps_datapath #(
    .GENOME_MAX   (GENOME_MAX),
    .PROMOTER_MAX (PROMOTER_MAX)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .st        (st),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
